// ----- rtl/acs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acs_pkg
// Shared widths, codes, types and a helper function of the accumulator CPU
// step unit.
// ----------------------------------------------------------------------------
package acs_pkg;

  // Field widths.
  localparam int DATA_W = 16;
  localparam int PC_W   = 12;
  localparam int MS_W   = 13;
  localparam int CMD_W  = 2;

  // Default number of memory words.
  localparam int MEM_WORDS_DEF = 4096;

  // Reset value of the memory size register.
  localparam logic [MS_W-1:0] MEM_SIZE_RST = 13'd4096;

  // Configuration register word index (paddr bit 2).
  localparam logic CFG_MEM_SIZE = 1'b0;

  // Item commands.
  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_EXEC  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  // Instruction opcodes (top nibble); other codes do nothing.
  typedef enum logic [3:0] {
    OP_NOP  = 4'h0,
    OP_LDA  = 4'h1,
    OP_STA  = 4'h2,
    OP_JMP  = 4'h3,
    OP_JNZ  = 4'h4,
    OP_RET  = 4'h5,
    OP_ARIT = 4'h6,
    OP_HALT = 4'hF
  } op_e;

  // Arithmetic operations.
  typedef enum logic [2:0] {
    ALU_ONES = 3'd0,
    ALU_ZERO = 3'd1,
    ALU_NOT  = 3'd2,
    ALU_AND  = 3'd3,
    ALU_OR   = 3'd4,
    ALU_XOR  = 3'd5,
    ALU_ADD  = 3'd6,
    ALU_SUB  = 3'd7
  } alu_e;

  // Register select codes; the remaining codes are unused.
  localparam logic [2:0] REG_A = 3'd0;
  localparam logic [2:0] REG_B = 3'd1;
  localparam logic [2:0] REG_C = 3'd2;
  localparam logic [2:0] REG_D = 3'd3;
  localparam logic [2:0] REG_R = 3'd6;

  // Control states of the item sequencer.
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_ITEM = 2'd1,
    ST_LOAD = 2'd2
  } state_e;

  // Architectural register set.
  typedef struct packed {
    logic [DATA_W-1:0] acc;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] c;
    logic [DATA_W-1:0] d;
    logic [DATA_W-1:0] link;
  } regs_t;

  // Outcome of one decoded instruction, handed from the execute unit.
  typedef struct packed {
    regs_t             regs;
    logic [PC_W-1:0]   pc;
    logic              stop;
    logic              ld;
    logic              st;
    logic              tgt_rng;
    logic [PC_W-1:0]   tgt;
  } ex_t;

  // A new program counter at or above the effective size wraps to zero.
  function automatic logic [PC_W-1:0] fit_pc(logic [DATA_W-1:0] v,
                                             logic [MS_W-1:0]   eff);
    logic [PC_W-1:0] r;
    if ({3'b000, eff} <= v) begin
      r = '0;
    end else begin
      r = v[PC_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/acs_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acs_in_if / acs_out_if
// Valid/ready channels that carry command items into the unit and result
// items out of it.
// ----------------------------------------------------------------------------
interface acs_in_if;
  logic                          valid;
  logic                          ready;
  logic [acs_pkg::CMD_W-1:0]     cmd;
  logic [acs_pkg::PC_W-1:0]      addr;
  logic [acs_pkg::DATA_W-1:0]    wdata;

  modport source (output valid, cmd, addr, wdata, input ready);
  modport sink   (input valid, cmd, addr, wdata, output ready);
endinterface

interface acs_out_if;
  logic                          valid;
  logic                          ready;
  logic [acs_pkg::DATA_W-1:0]    rdata;
  logic [acs_pkg::PC_W-1:0]      pc_now;
  logic [acs_pkg::DATA_W-1:0]    acc_now;
  logic                          halted;

  modport source (output valid, rdata, pc_now, acc_now, halted, input ready);
  modport sink   (input valid, rdata, pc_now, acc_now, halted, output ready);
endinterface

// ----- rtl/acs_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acs_mem
// Word memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module acs_mem #(
  parameter int  MEM_WORDS = acs_pkg::MEM_WORDS_DEF,
  localparam int AW        = $clog2(MEM_WORDS)
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [acs_pkg::DATA_W-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [AW-1:0]              raddr_i,
  output logic [acs_pkg::DATA_W-1:0] rdata_o
);

  logic [acs_pkg::DATA_W-1:0] mem_q [MEM_WORDS];
  logic [acs_pkg::DATA_W-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/acs_exec.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acs_exec
// Decodes one fetched instruction and computes the next register set,
// program counter and memory request.
// ----------------------------------------------------------------------------
module acs_exec #(
  parameter int MEM_WORDS = acs_pkg::MEM_WORDS_DEF
) (
  input  logic [acs_pkg::DATA_W-1:0] ins_i,
  input  logic [acs_pkg::PC_W-1:0]   pc_i,
  input  acs_pkg::regs_t             regs_i,
  input  logic                       stop_i,
  input  logic [acs_pkg::MS_W-1:0]   eff_i,
  output acs_pkg::ex_t               ex_o
);

  logic [acs_pkg::MS_W-1:0]   nxt;
  logic [acs_pkg::DATA_W-1:0] pc_new;
  logic [acs_pkg::DATA_W-1:0] x;
  logic [acs_pkg::DATA_W-1:0] y;
  logic [acs_pkg::DATA_W-1:0] res;
  acs_pkg::regs_t             regs;

  // Register read by select code; unused codes read zero.
  function automatic logic [acs_pkg::DATA_W-1:0] reg_rd(logic [2:0] code,
                                                        acs_pkg::regs_t r);
    logic [acs_pkg::DATA_W-1:0] v;
    v = '0;
    if (code == acs_pkg::REG_A) v = r.acc;
    if (code == acs_pkg::REG_B) v = r.b;
    if (code == acs_pkg::REG_C) v = r.c;
    if (code == acs_pkg::REG_D) v = r.d;
    if (code == acs_pkg::REG_R) v = r.link;
    return v;
  endfunction

  // Arithmetic operands and result.
  always_comb begin
    x = reg_rd(ins_i[5:3], regs_i);
    y = ins_i[2] ? reg_rd({1'b0, ins_i[1:0]}, regs_i) : '0;
    unique case (acs_pkg::alu_e'(ins_i[11:9]))
      acs_pkg::ALU_ONES: res = '1;
      acs_pkg::ALU_ZERO: res = '0;
      acs_pkg::ALU_NOT:  res = ~x;
      acs_pkg::ALU_AND:  res = x & y;
      acs_pkg::ALU_OR:   res = x | y;
      acs_pkg::ALU_XOR:  res = x ^ y;
      acs_pkg::ALU_ADD:  res = x + y;
      acs_pkg::ALU_SUB:  res = x - y;
      default:           res = '0;
    endcase
  end

  // Opcode decode and next program counter.
  always_comb begin
    nxt    = {1'b0, pc_i} + 13'd1;
    pc_new = 16'(nxt);
    regs   = regs_i;
    ex_o   = '0;
    ex_o.stop = stop_i;
    unique case (acs_pkg::op_e'(ins_i[15:12]))
      acs_pkg::OP_LDA: ex_o.ld = 1'b1;
      acs_pkg::OP_STA: ex_o.st = 1'b1;
      acs_pkg::OP_JMP: begin
        regs.link = 16'(nxt);
        pc_new    = {4'h0, ins_i[11:0]};
      end
      acs_pkg::OP_JNZ: begin
        regs.link = 16'(nxt);
        if (regs_i.acc != '0) pc_new = {4'h0, ins_i[11:0]};
      end
      acs_pkg::OP_RET: pc_new = regs_i.link;
      acs_pkg::OP_ARIT: begin
        // Writes to unused destination codes are dropped.
        if (ins_i[8:6] == acs_pkg::REG_A) regs.acc  = res;
        if (ins_i[8:6] == acs_pkg::REG_B) regs.b    = res;
        if (ins_i[8:6] == acs_pkg::REG_C) regs.c    = res;
        if (ins_i[8:6] == acs_pkg::REG_D) regs.d    = res;
        if (ins_i[8:6] == acs_pkg::REG_R) regs.link = res;
      end
      acs_pkg::OP_HALT: ex_o.stop = 1'b1;
      default: ;
    endcase
    ex_o.regs    = regs;
    ex_o.pc      = acs_pkg::fit_pc(pc_new, eff_i);
    ex_o.tgt     = ins_i[11:0];
    ex_o.tgt_rng = ({1'b0, ins_i[11:0]} < 13'(MEM_WORDS));
  end

endmodule

// ----- rtl/accumulator_cpu_step_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accumulator_cpu_step_unit
// 16-bit accumulator processor stepped one command at a time, with its word
// memory inside.
// ----------------------------------------------------------------------------
// Every accepted item reads the word memory in its acceptance cycle (the word
// at addr for a read, the instruction at the program counter for an execute)
// and its result is registered from the item state once the result register is
// free, in the same cycle in which the next item may be accepted; writes, reads
// and most instructions therefore run at one item per cycle while the result
// side does not stall. LDA needs a second read of the single memory read port
// and STA uses the write port in its result cycle, so each of them holds off the
// next item. The result register parts the output side: one item can be accepted
// while a finished result waits to be taken. The memory is not cleared after
// reset; a word must be written before it is read.
// ----------------------------------------------------------------------------
module accumulator_cpu_step_unit #(
  parameter int  MEM_WORDS = acs_pkg::MEM_WORDS_DEF,
  localparam int AW        = $clog2(MEM_WORDS)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  acs_in_if.sink           in_i,
  acs_out_if.source        out_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  acs_pkg::state_e            st_q, st_d;
  logic [acs_pkg::CMD_W-1:0]  cmd_q;
  logic                       rng_q;
  logic                       ld_rng_q, ld_rng_d;
  logic [acs_pkg::PC_W-1:0]   pc_q, pc_d;
  acs_pkg::regs_t             regs_q, regs_d;
  logic                       stop_q, stop_d;
  logic [acs_pkg::MS_W-1:0]   ms_q, ms_d;
  logic [acs_pkg::MS_W-1:0]   eff_q, eff_d;

  logic                       out_vld_q;
  logic [acs_pkg::DATA_W-1:0] out_rdata_q, out_rdata_d;
  logic [acs_pkg::PC_W-1:0]   out_pc_q;
  logic [acs_pkg::DATA_W-1:0] out_acc_q;
  logic                       out_halt_q;

  logic                       in_acc;
  logic                       out_free;
  logic                       exec;
  logic                       is_lda;
  logic                       is_sta;
  logic                       fin_item;
  logic                       fin_load;
  logic                       cfg_we;
  logic                       in_rng;

  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [acs_pkg::DATA_W-1:0] mem_wdata;
  logic                       mem_re;
  logic [AW-1:0]              mem_raddr;
  logic [acs_pkg::DATA_W-1:0] mem_rd;

  acs_pkg::ex_t               ex;

  // Word memory.
  acs_mem #(
    .MEM_WORDS (MEM_WORDS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rd)
  );

  // Execute unit, fed with the fetched instruction.
  acs_exec #(
    .MEM_WORDS (MEM_WORDS)
  ) u_exec (
    .ins_i  (mem_rd),
    .pc_i   (pc_q),
    .regs_i (regs_q),
    .stop_i (stop_q),
    .eff_i  (eff_q),
    .ex_o   (ex)
  );

  // Configuration port.
  assign cfg_we = psel && penable && pwrite && (paddr[2] == acs_pkg::CFG_MEM_SIZE);
  assign prdata = (paddr[2] == acs_pkg::CFG_MEM_SIZE) ? {19'b0, ms_q} : '0;
  assign pready = 1'b1;

  // Handshake and sequencing conditions.
  assign out_free = !out_vld_q || out_o.ready;
  assign exec     = (st_q == acs_pkg::ST_ITEM) && (cmd_q == acs_pkg::CMD_EXEC) && !stop_q;
  assign is_lda   = exec && ex.ld;
  assign is_sta   = exec && ex.st;
  assign fin_item = (st_q == acs_pkg::ST_ITEM) && !is_lda && out_free;
  assign fin_load = (st_q == acs_pkg::ST_LOAD) && out_free;
  assign in_i.ready = (st_q == acs_pkg::ST_IDLE) || (fin_item && !is_sta) || fin_load;
  assign in_acc   = in_i.valid && in_i.ready;
  assign in_rng   = ({1'b0, in_i.addr} < 13'(MEM_WORDS));

  // Next architectural state.
  always_comb begin
    pc_d     = pc_q;
    regs_d   = regs_q;
    stop_d   = stop_q;
    ms_d     = ms_q;
    eff_d    = eff_q;
    ld_rng_d = ld_rng_q;
    if (is_lda) begin
      pc_d     = ex.pc;
      ld_rng_d = ex.tgt_rng;
    end else if (fin_item && exec) begin
      pc_d   = ex.pc;
      regs_d = ex.regs;
      stop_d = ex.stop;
    end
    if (fin_load) begin
      regs_d.acc = ld_rng_q ? mem_rd : '0;
    end
    // Writing the memory size also loads the link register.
    if (cfg_we) begin
      ms_d        = pwdata[acs_pkg::MS_W-1:0];
      regs_d.link = {3'b000, pwdata[acs_pkg::MS_W-1:0]};
      if (ms_d == '0) begin
        eff_d = 13'd1;
      end else if (ms_d > 13'(MEM_WORDS)) begin
        eff_d = 13'(MEM_WORDS);
      end else begin
        eff_d = ms_d;
      end
    end
  end

  // Memory port control; the fetch of a new item sees the forwarded pc.
  always_comb begin
    mem_re    = in_acc || is_lda;
    mem_raddr = (in_i.cmd == acs_pkg::CMD_EXEC) ? pc_d[AW-1:0] : in_i.addr[AW-1:0];
    if (is_lda) begin
      mem_raddr = ex.tgt[AW-1:0];
    end
    mem_we    = in_acc && (in_i.cmd == acs_pkg::CMD_WRITE) && in_rng;
    mem_waddr = in_i.addr[AW-1:0];
    mem_wdata = in_i.wdata;
    if (fin_item && is_sta) begin
      mem_we    = ex.tgt_rng;
      mem_waddr = ex.tgt[AW-1:0];
      mem_wdata = regs_q.acc;
    end
  end

  // Sequencer next state.
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      acs_pkg::ST_IDLE: begin
        if (in_acc) st_d = acs_pkg::ST_ITEM;
      end
      acs_pkg::ST_ITEM: begin
        if (is_lda) begin
          st_d = acs_pkg::ST_LOAD;
        end else if (out_free) begin
          st_d = in_acc ? acs_pkg::ST_ITEM : acs_pkg::ST_IDLE;
        end
      end
      acs_pkg::ST_LOAD: begin
        if (out_free) st_d = in_acc ? acs_pkg::ST_ITEM : acs_pkg::ST_IDLE;
      end
      default: st_d = acs_pkg::ST_IDLE;
    endcase
  end

  // Control and architectural registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= acs_pkg::ST_IDLE;
      cmd_q     <= acs_pkg::CMD_NOP;
      rng_q     <= 1'b0;
      ld_rng_q  <= 1'b0;
      pc_q      <= '0;
      regs_q    <= '{acc: '0, b: '0, c: '0, d: '0, link: 16'(acs_pkg::MEM_SIZE_RST)};
      stop_q    <= 1'b0;
      ms_q      <= acs_pkg::MEM_SIZE_RST;
      eff_q     <= 13'(MEM_WORDS);
      out_vld_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      ld_rng_q <= ld_rng_d;
      pc_q     <= pc_d;
      regs_q   <= regs_d;
      stop_q   <= stop_d;
      ms_q     <= ms_d;
      eff_q    <= eff_d;
      if (in_acc) begin
        cmd_q <= in_i.cmd;
        rng_q <= in_rng;
      end
      if (fin_item || fin_load) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Result register.
  assign out_rdata_d = (cmd_q == acs_pkg::CMD_READ && rng_q) ? mem_rd : '0;

  always_ff @(posedge clk_i) begin
    if (fin_item || fin_load) begin
      out_rdata_q <= fin_item ? out_rdata_d : '0;
      out_pc_q    <= pc_d;
      out_acc_q   <= regs_d.acc;
      out_halt_q  <= stop_d;
    end
  end

  assign out_o.valid   = out_vld_q;
  assign out_o.rdata   = out_rdata_q;
  assign out_o.pc_now  = out_pc_q;
  assign out_o.acc_now = out_acc_q;
  assign out_o.halted  = out_halt_q;

  // The operand load state is only ever entered from the instruction state.
  a_load_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == acs_pkg::ST_LOAD) && ($past(st_q) != acs_pkg::ST_LOAD)
      |-> $past(st_q) == acs_pkg::ST_ITEM)
    else $error("operand load entered from wrong state");

  // An accepted item always puts the sequencer in the instruction state in the next cycle.
  a_accept_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> st_q == acs_pkg::ST_ITEM)
    else $error("accepted item not held for execution");

  // Halt is sticky.
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stop_q |=> stop_q)
    else $error("halt flag cleared");

  // The memory is never written in the cycle that issues an operand read.
  a_no_write_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == acs_pkg::ST_ITEM) && is_lda |-> !mem_we)
    else $error("memory written during operand read");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the accumulator CPU step unit. Command items go in
// over a valid/ready channel and every result is compared field by field with
// a cycle-free shadow of the processor. A short stimulus table comes first,
// then random phases that each set a new memory size over the register port.
// ----------------------------------------------------------------------------
module testbench;

  localparam int MEM_WORDS    = acs_pkg::MEM_WORDS_DEF;
  localparam int IDLE_LIMIT   = 2000;
  localparam int PHASE_ITEMS  = 95;
  localparam int SETTLE_TICKS = 4;

  // Register port address of the memory size register.
  localparam logic [2:0] MEM_SIZE_ADDR = {acs_pkg::CFG_MEM_SIZE, 2'b00};

  // Register select codes that name no register.
  localparam logic [2:0] REG_UNUSED_LO = 3'd4;
  localparam logic [2:0] REG_UNUSED_HI = 3'd7;

  // One result transfer as the unit reports it.
  typedef struct packed {
    logic [acs_pkg::DATA_W-1:0] rdata;
    logic [acs_pkg::PC_W-1:0]   pc_now;
    logic [acs_pkg::DATA_W-1:0] acc_now;
    logic                       halted;
  } cpu_result_t;

  // One row of the stimulus table.
  typedef struct {
    acs_pkg::cmd_e              cmd;
    logic [acs_pkg::PC_W-1:0]   addr;
    logic [acs_pkg::DATA_W-1:0] wdata;
    bit                         typed;
    cpu_result_t                result;
  } table_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  acs_in_if  cmd_ch ();
  acs_out_if res_ch ();

  accumulator_cpu_step_unit DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (cmd_ch),
    .out_o   (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow of the processor state.
  logic [acs_pkg::DATA_W-1:0] cpu_mem [MEM_WORDS];
  bit                         cpu_written [MEM_WORDS];
  logic [acs_pkg::PC_W-1:0]   written_addrs [$];
  logic [acs_pkg::PC_W-1:0]   cpu_pc;
  logic [acs_pkg::DATA_W-1:0] cpu_acc;
  logic [acs_pkg::DATA_W-1:0] cpu_b;
  logic [acs_pkg::DATA_W-1:0] cpu_c;
  logic [acs_pkg::DATA_W-1:0] cpu_d;
  logic [acs_pkg::DATA_W-1:0] cpu_link;
  logic                       cpu_stopped;
  logic [acs_pkg::MS_W-1:0]   cpu_mem_size;

  cpu_result_t expected_results [$];
  cpu_result_t head_result;
  int          error_count = 0;
  int          idle_cycles = 0;
  int          stall_left  = 0;
  bit          src_idle_en = 1'b0;
  bit          snk_idle_en = 1'b0;

  // Clock with a 10 ns period.
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Effective number of words the program counter runs over.
  function automatic int eff_words();
    if (cpu_mem_size == '0) return 1;
    if (cpu_mem_size > MEM_WORDS) return MEM_WORDS;
    return int'(cpu_mem_size);
  endfunction

  function automatic void store_word(logic [acs_pkg::PC_W-1:0] a,
                                     logic [acs_pkg::DATA_W-1:0] v);
    cpu_mem[a] = v;
    if (!cpu_written[a]) begin
      cpu_written[a] = 1'b1;
      written_addrs.push_back(a);
    end
  endfunction

  function automatic logic [acs_pkg::DATA_W-1:0] reg_value(logic [2:0] code);
    case (code)
      acs_pkg::REG_A: return cpu_acc;
      acs_pkg::REG_B: return cpu_b;
      acs_pkg::REG_C: return cpu_c;
      acs_pkg::REG_D: return cpu_d;
      acs_pkg::REG_R: return cpu_link;
      default:        return '0;
    endcase
  endfunction

  // Applies one command to the shadow state and returns the result it gives.
  function automatic cpu_result_t cpu_step(acs_pkg::cmd_e c, logic [acs_pkg::PC_W-1:0] a,
                                           logic [acs_pkg::DATA_W-1:0] w);
    cpu_result_t                r;
    logic [acs_pkg::DATA_W-1:0] ins;
    logic [acs_pkg::DATA_W-1:0] x;
    logic [acs_pkg::DATA_W-1:0] y;
    logic [acs_pkg::DATA_W-1:0] res;
    int                         nxt;
    r = '0;
    case (c)
      acs_pkg::CMD_WRITE: store_word(a, w);
      acs_pkg::CMD_READ:  r.rdata = cpu_mem[a];
      acs_pkg::CMD_EXEC: begin
        if (!cpu_stopped) begin
          ins = cpu_mem[cpu_pc];
          nxt = int'(cpu_pc) + 1;
          case (ins[15:12])
            acs_pkg::OP_LDA: cpu_acc = cpu_mem[ins[acs_pkg::PC_W-1:0]];
            acs_pkg::OP_STA: store_word(ins[acs_pkg::PC_W-1:0], cpu_acc);
            acs_pkg::OP_JMP: begin
              cpu_link = acs_pkg::DATA_W'(nxt);
              nxt = int'(ins[acs_pkg::PC_W-1:0]);
            end
            acs_pkg::OP_JNZ: begin
              cpu_link = acs_pkg::DATA_W'(nxt);
              if (cpu_acc != '0) nxt = int'(ins[acs_pkg::PC_W-1:0]);
            end
            acs_pkg::OP_RET: nxt = int'(cpu_link);
            acs_pkg::OP_ARIT: begin
              x = reg_value(ins[5:3]);
              y = ins[2] ? reg_value({1'b0, ins[1:0]}) : '0;
              case (acs_pkg::alu_e'(ins[11:9]))
                acs_pkg::ALU_ONES: res = '1;
                acs_pkg::ALU_ZERO: res = '0;
                acs_pkg::ALU_NOT:  res = ~x;
                acs_pkg::ALU_AND:  res = x & y;
                acs_pkg::ALU_OR:   res = x | y;
                acs_pkg::ALU_XOR:  res = x ^ y;
                acs_pkg::ALU_ADD:  res = x + y;
                default:           res = x - y;
              endcase
              // Writes to an unused register code are dropped.
              case (ins[8:6])
                acs_pkg::REG_A: cpu_acc  = res;
                acs_pkg::REG_B: cpu_b    = res;
                acs_pkg::REG_C: cpu_c    = res;
                acs_pkg::REG_D: cpu_d    = res;
                acs_pkg::REG_R: cpu_link = res;
                default: ;
              endcase
            end
            acs_pkg::OP_HALT: cpu_stopped = 1'b1;
            default: ;
          endcase
          cpu_pc = (nxt >= eff_words()) ? '0 : acs_pkg::PC_W'(nxt);
        end
      end
      default: ;
    endcase
    r.pc_now  = cpu_pc;
    r.acc_now = cpu_acc;
    r.halted  = cpu_stopped;
    return r;
  endfunction

  function automatic logic [acs_pkg::DATA_W-1:0] ins_mem(acs_pkg::op_e op,
                                                         logic [acs_pkg::PC_W-1:0] t);
    return {op, t};
  endfunction

  function automatic logic [acs_pkg::DATA_W-1:0] ins_alu(acs_pkg::alu_e f, logic [2:0] dst,
                                                         logic [2:0] src1, bit use2,
                                                         logic [2:0] src2);
    return {acs_pkg::OP_ARIT, f, dst, src1, use2, src2[1:0]};
  endfunction

  // Random instruction; jump and store targets mostly land inside the
  // effective size, and loads only read words already written.
  function automatic logic [acs_pkg::DATA_W-1:0] random_instr(bit halt_ok);
    int                       pick;
    logic [acs_pkg::PC_W-1:0] tgt;
    logic [3:0]               undef_op;
    pick     = $urandom_range(0, 99);
    tgt      = ($urandom_range(0, 3) == 0) ? acs_pkg::PC_W'($urandom)
               : acs_pkg::PC_W'($urandom_range(0, eff_words() - 1));
    undef_op = 4'($urandom_range(int'(acs_pkg::OP_ARIT) + 1, int'(acs_pkg::OP_HALT) - 1));
    if (pick < 14) begin
      return ins_mem(acs_pkg::OP_LDA,
                     written_addrs[$urandom_range(0, written_addrs.size() - 1)]);
    end else if (pick < 28) begin
      return ins_mem(acs_pkg::OP_STA, tgt);
    end else if (pick < 38) begin
      return ins_mem(acs_pkg::OP_JMP, tgt);
    end else if (pick < 50) begin
      return ins_mem(acs_pkg::OP_JNZ, tgt);
    end else if (pick < 58) begin
      return ins_mem(acs_pkg::OP_RET, acs_pkg::PC_W'($urandom));
    end else if (pick < 88) begin
      return ins_mem(acs_pkg::OP_ARIT, acs_pkg::PC_W'($urandom));
    end else if (pick < 92) begin
      return ins_mem(acs_pkg::OP_NOP, acs_pkg::PC_W'($urandom));
    end else if (halt_ok && pick < 95) begin
      return ins_mem(acs_pkg::OP_HALT, acs_pkg::PC_W'($urandom));
    end
    return {undef_op, acs_pkg::PC_W'($urandom)};
  endfunction

  // Drives one command transfer and queues its expected result on acceptance.
  task automatic send_cmd(input acs_pkg::cmd_e c, input logic [acs_pkg::PC_W-1:0] a,
                          input logic [acs_pkg::DATA_W-1:0] w, input bit typed,
                          input cpu_result_t typed_res);
    cpu_result_t predicted;
    if (src_idle_en && $urandom_range(0, 4) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.cmd   <= c;
    cmd_ch.addr  <= a;
    cmd_ch.wdata <= w;
    do @(posedge clk_i); while (!(cmd_ch.valid && cmd_ch.ready));
    predicted = cpu_step(c, a, w);
    expected_results.push_back(typed ? typed_res : predicted);
    @(negedge clk_i);
  endtask

  // Holds the sender off until every expected result has arrived.
  task automatic drain_results();
    cmd_ch.valid <= 1'b0;
    do @(negedge clk_i); while (expected_results.size() != 0);
    repeat (SETTLE_TICKS) @(negedge clk_i);
  endtask

  // Result side: random stalls in bursts of random length when enabled.
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      res_ch.ready <= 1'b0;
    end else if (snk_idle_en && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 5);
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // Compare every result transfer with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: pc_now %h acc_now %h", res_ch.pc_now, res_ch.acc_now);
        error_count++;
      end else begin
        head_result = expected_results.pop_front();
        if (res_ch.rdata !== head_result.rdata) begin
          $error("rdata: expected %h, actual %h", head_result.rdata, res_ch.rdata);
          error_count++;
        end
        if (res_ch.pc_now !== head_result.pc_now) begin
          $error("pc_now: expected %h, actual %h", head_result.pc_now, res_ch.pc_now);
          error_count++;
        end
        if (res_ch.acc_now !== head_result.acc_now) begin
          $error("acc_now: expected %h, actual %h", head_result.acc_now, res_ch.acc_now);
          error_count++;
        end
        if (res_ch.halted !== head_result.halted) begin
          $error("halted: expected %b, actual %b", head_result.halted, res_ch.halted);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer on either channel.
  always @(posedge clk_i) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("accumulator_cpu_step_unit verification failed");
      $finish;
    end
  end

  initial begin
    table_row_t               rows [$];
    logic [acs_pkg::MS_W-1:0] sizes [10];
    int                       pick;
    bit                       halt_ok;

    // Every input known from time zero; reset held low before the stimulus.
    rst_ni       = 1'b0;
    cmd_ch.valid = 1'b0;
    cmd_ch.cmd   = acs_pkg::CMD_NOP;
    cmd_ch.addr  = '0;
    cmd_ch.wdata = '0;
    res_ch.ready = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    cpu_pc       = '0;
    cpu_acc      = '0;
    cpu_b        = '0;
    cpu_c        = '0;
    cpu_d        = '0;
    cpu_mem_size = acs_pkg::MEM_SIZE_RST;
    cpu_link     = acs_pkg::DATA_W'(acs_pkg::MEM_SIZE_RST);
    cpu_stopped  = 1'b0;
    foreach (cpu_mem[i]) begin
      cpu_mem[i]     = '0;
      cpu_written[i] = 1'b0;
    end
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Stimulus table: reset state, field extremes, loads, arithmetic, a store,
    // unused register codes, a taken branch, a return and a far jump.
    rows.push_back('{acs_pkg::CMD_NOP, 12'h000, 16'h0000, 1'b1,
                     '{16'h0000, 12'h000, 16'h0000, 1'b0}});
    rows.push_back('{acs_pkg::CMD_WRITE, 12'hFFF, 16'hFFFF, 1'b1,
                     '{16'h0000, 12'h000, 16'h0000, 1'b0}});
    rows.push_back('{acs_pkg::CMD_READ, 12'hFFF, 16'h0000, 1'b1,
                     '{16'hFFFF, 12'h000, 16'h0000, 1'b0}});
    rows.push_back('{acs_pkg::CMD_WRITE, 12'h000, ins_mem(acs_pkg::OP_LDA, 12'hFFF), 1'b1,
                     '{16'h0000, 12'h000, 16'h0000, 1'b0}});
    rows.push_back('{acs_pkg::CMD_EXEC, 12'h000, 16'h0000, 1'b1,
                     '{16'h0000, 12'h001, 16'hFFFF, 1'b0}});
    rows.push_back('{acs_pkg::CMD_WRITE, 12'h001,
                     ins_alu(acs_pkg::ALU_ADD, acs_pkg::REG_B, acs_pkg::REG_A, 1'b1,
                             acs_pkg::REG_A), 1'b0, '0});
    rows.push_back('{acs_pkg::CMD_EXEC, 12'h000, 16'h0000, 1'b0, '0});
    rows.push_back('{acs_pkg::CMD_WRITE, 12'h002,
                     ins_alu(acs_pkg::ALU_SUB, acs_pkg::REG_A, acs_pkg::REG_B, 1'b1,
                             acs_pkg::REG_A), 1'b0, '0});
    rows.push_back('{acs_pkg::CMD_EXEC, 12'h000, 16'h0000, 1'b0, '0});
    rows.push_back('{acs_pkg::CMD_WRITE, 12'h003,
                     ins_alu(acs_pkg::ALU_ADD, acs_pkg::REG_C, REG_UNUSED_LO, 1'b1,
                             acs_pkg::REG_B), 1'b0, '0});
    rows.push_back('{acs_pkg::CMD_EXEC, 12'h000, 16'h0000, 1'b0, '0});
    rows.push_back('{acs_pkg::CMD_WRITE, 12'h004,
                     ins_alu(acs_pkg::ALU_ONES, REG_UNUSED_HI, acs_pkg::REG_A, 1'b0,
                             acs_pkg::REG_A), 1'b0, '0});
    rows.push_back('{acs_pkg::CMD_EXEC, 12'h000, 16'h0000, 1'b0, '0});
    rows.push_back('{acs_pkg::CMD_WRITE, 12'h005, ins_mem(acs_pkg::OP_STA, 12'h800),
                     1'b0, '0});
    rows.push_back('{acs_pkg::CMD_EXEC, 12'h000, 16'h0000, 1'b0, '0});
    rows.push_back('{acs_pkg::CMD_READ, 12'h800, 16'h0000, 1'b0, '0});
    rows.push_back('{acs_pkg::CMD_WRITE, 12'h006, ins_mem(acs_pkg::OP_JNZ, 12'h009),
                     1'b0, '0});
    rows.push_back('{acs_pkg::CMD_EXEC, 12'h000, 16'h0000, 1'b0, '0});
    rows.push_back('{acs_pkg::CMD_WRITE, 12'h009, ins_mem(acs_pkg::OP_RET, 12'h000),
                     1'b0, '0});
    rows.push_back('{acs_pkg::CMD_EXEC, 12'h000, 16'h0000, 1'b0, '0});
    rows.push_back('{acs_pkg::CMD_WRITE, 12'h007, ins_mem(acs_pkg::OP_JMP, 12'hFFE),
                     1'b0, '0});
    rows.push_back('{acs_pkg::CMD_WRITE, 12'hFFE,
                     ins_alu(acs_pkg::ALU_NOT, acs_pkg::REG_A, acs_pkg::REG_R, 1'b0,
                             acs_pkg::REG_A), 1'b0, '0});
    rows.push_back('{acs_pkg::CMD_EXEC, 12'h000, 16'h0000, 1'b0, '0});
    rows.push_back('{acs_pkg::CMD_EXEC, 12'h000, 16'h0000, 1'b0, '0});
    foreach (rows[i]) begin
      send_cmd(rows[i].cmd, rows[i].addr, rows[i].wdata, rows[i].typed, rows[i].result);
    end

    // Random phases, each under its own memory size; the last one runs
    // without idling and is the only one allowed to halt the processor.
    sizes = '{13'd1, 13'd0, 13'd8191, 13'd16, 13'd4097, 13'd3, 13'd4096, 13'd257, 13'd2,
              13'd64};
    foreach (sizes[p]) begin
      halt_ok = (p == 9);
      drain_results();

      // Write the memory size register, then read it back.
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= MEM_SIZE_ADDR;
      pwdata  <= 32'(sizes[p]);
      @(negedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
      cpu_mem_size = sizes[p];
      cpu_link     = acs_pkg::DATA_W'(sizes[p]);
      @(negedge clk_i);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
      if (prdata[acs_pkg::MS_W-1:0] !== sizes[p]) begin
        $error("mem_size: expected %0d, actual %0d", sizes[p], prdata[acs_pkg::MS_W-1:0]);
        error_count++;
      end
      @(negedge clk_i);
      psel    <= 1'b0;
      penable <= 1'b0;

      src_idle_en = !halt_ok && ($urandom_range(0, 2) != 0);
      snk_idle_en = !halt_ok && ($urandom_range(0, 2) != 0);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          // Make sure the word at the program counter holds a usable
          // instruction before stepping the processor.
          if (!cpu_written[cpu_pc] ||
              (!halt_ok && cpu_mem[cpu_pc][15:12] == acs_pkg::OP_HALT)) begin
            send_cmd(acs_pkg::CMD_WRITE, cpu_pc, random_instr(halt_ok), 1'b0, '0);
          end
          send_cmd(acs_pkg::CMD_EXEC, acs_pkg::PC_W'($urandom),
                   acs_pkg::DATA_W'($urandom), 1'b0, '0);
        end else if (pick < 70) begin
          send_cmd(acs_pkg::CMD_WRITE, acs_pkg::PC_W'($urandom_range(0, eff_words() - 1)),
                   random_instr(halt_ok), 1'b0, '0);
        end else if (pick < 80) begin
          send_cmd(acs_pkg::CMD_WRITE, acs_pkg::PC_W'($urandom),
                   acs_pkg::DATA_W'($urandom), 1'b0, '0);
        end else if (pick < 93) begin
          send_cmd(acs_pkg::CMD_READ,
                   written_addrs[$urandom_range(0, written_addrs.size() - 1)],
                   acs_pkg::DATA_W'($urandom), 1'b0, '0);
        end else if (pick < 98) begin
          send_cmd(acs_pkg::CMD_NOP, acs_pkg::PC_W'($urandom),
                   acs_pkg::DATA_W'($urandom), 1'b0, '0);
        end else begin
          drain_results();
        end
      end
    end

    // Halt for certain, then show that steps no longer change anything.
    send_cmd(acs_pkg::CMD_WRITE, cpu_pc,
             ins_mem(acs_pkg::OP_HALT, acs_pkg::PC_W'($urandom)), 1'b0, '0);
    send_cmd(acs_pkg::CMD_EXEC, '0, '0, 1'b0, '0);
    send_cmd(acs_pkg::CMD_EXEC, '0, '0, 1'b0, '0);
    send_cmd(acs_pkg::CMD_READ, written_addrs[0], '0, 1'b0, '0);

    drain_results();
    repeat (6) @(negedge clk_i);
    if (error_count == 0) begin
      $display("accumulator_cpu_step_unit verification clean");
    end else begin
      $display("accumulator_cpu_step_unit verification failed");
    end
    $finish;
  end

endmodule

// ----- accumulator_cpu_step_unit.f -----
rtl/acs_pkg.sv
rtl/acs_if.sv
rtl/acs_mem.sv
rtl/acs_exec.sv
rtl/accumulator_cpu_step_unit.sv
tb/testbench.sv
